FILE: rtl/ecgcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ecgcm_pkg;

  localparam int ITER_CAP = 4096;
  localparam int NPAL     = 4;
  localparam int NSTOP    = 7;

  localparam logic REG_PALETTE = 1'b0;
  localparam logic REG_LIMIT   = 1'b1;

  localparam logic [31:0] BLACK_PIXEL = 32'hFF00_0000;

  typedef logic [1:0] pal_t;
  typedef logic [2:0] seg_t;

  // Control that travels alongside the data through every cell.
  typedef struct packed {
    logic valid;
    logic black;
    pal_t pal;
    seg_t seg;
  } side_t;

  // Stop positions in Q1.16, 65536 meaning the end of the gradient.
  localparam logic [16:0] STOP_POS [NPAL][NSTOP] = '{
    '{17'd0, 17'd9830,  17'd22938, 17'd36045, 17'd49152, 17'd58982, 17'd65536},
    '{17'd0, 17'd13107, 17'd29491, 17'd45875, 17'd57672, 17'd65536, 17'd65536},
    '{17'd0, 17'd10486, 17'd21627, 17'd32768, 17'd43254, 17'd54395, 17'd65536},
    '{17'd0, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536}
  };

  // Stop colours as red, green, blue.
  localparam logic [7:0] STOP_RGB [NPAL][NSTOP][3] = '{
    '{'{8'd0, 8'd0, 8'd4}, '{8'd32, 8'd12, 8'd74}, '{8'd120, 8'd28, 8'd109},
      '{8'd205, 8'd60, 8'd79}, '{8'd246, 8'd133, 8'd41}, '{8'd252, 8'd214, 8'd106},
      '{8'd255, 8'd255, 8'd235}},
    '{'{8'd2, 8'd4, 8'd24}, '{8'd12, 8'd44, 8'd92}, '{8'd26, 8'd108, 8'd160},
      '{8'd88, 8'd180, 8'd208}, '{8'd176, 8'd226, 8'd233}, '{8'd245, 8'd253, 8'd255},
      '{8'd245, 8'd253, 8'd255}},
    '{'{8'd8, 8'd0, 8'd32}, '{8'd60, 8'd12, 8'd140}, '{8'd20, 8'd90, 8'd200},
      '{8'd20, 8'd170, 8'd130}, '{8'd190, 8'd200, 8'd40}, '{8'd230, 8'd90, 8'd40},
      '{8'd255, 8'd235, 8'd220}},
    '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255},
      '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255},
      '{8'd255, 8'd255, 8'd255}}
  };

endpackage
`default_nettype wire

FILE: rtl/ecgcm_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ecgcm_div_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire ecgcm_pkg::side_t   side_i,
  input  wire logic [16:0]        rem_i,
  input  wire logic [16:0]        div_i,
  input  wire logic [31:0]        quo_i,
  output ecgcm_pkg::side_t        side_o,
  output logic [16:0]             rem_o,
  output logic [16:0]             div_o,
  output logic [31:0]             quo_o
);
  import ecgcm_pkg::*;

  side_t       side_r;
  logic [16:0] rem_r, rem_nxt;
  logic [16:0] div_r;
  logic [31:0] quo_r, quo_nxt;
  logic [17:0] dbl;
  logic        ge;

  // One restoring step: shift a zero into the remainder, subtract if it fits.
  always_comb begin
    dbl     = {rem_i, 1'b0};
    ge      = dbl >= {1'b0, div_i};
    rem_nxt = ge ? 17'(dbl - {1'b0, div_i}) : dbl[16:0];
    quo_nxt = {quo_i[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (adv) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt;
      div_r <= div_i;
      quo_r <= quo_nxt;
    end
  end

  assign side_o = side_r;
  assign rem_o  = rem_r;
  assign div_o  = div_r;
  assign quo_o  = quo_r;

endmodule
`default_nettype wire

FILE: rtl/ecgcm_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ecgcm_sqrt_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire ecgcm_pkg::side_t   side_i,
  input  wire logic [31:0]        v_i,
  input  wire logic [18:0]        rem_i,
  input  wire logic [15:0]        root_i,
  output ecgcm_pkg::side_t        side_o,
  output logic [31:0]             v_o,
  output logic [18:0]             rem_o,
  output logic [15:0]             root_o
);
  import ecgcm_pkg::*;

  side_t       side_r;
  logic [31:0] v_r;
  logic [18:0] rem_r, rem_nxt;
  logic [15:0] root_r, root_nxt;
  logic [18:0] cur, trial;
  logic        ge;

  // One digit of the root: bring down two bits, try (root*4 + 1).
  always_comb begin
    cur      = {rem_i[16:0], v_i[31:30]};
    trial    = {1'b0, root_i, 2'b01};
    ge       = cur >= trial;
    rem_nxt  = ge ? 19'(cur - trial) : cur;
    root_nxt = {root_i[14:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (adv) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r    <= {v_i[29:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign side_o = side_r;
  assign v_o    = v_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule
`default_nettype wire

FILE: rtl/escape_count_gradient_colour_map.sv
`timescale 1ns / 1ps
`default_nettype none
// Escape count to ABGR colour mapper.
// Input beats carry one escape count on in_escape_count with in_valid; the
// block holds in_stall high while it cannot take a beat. Result beats carry
// one opaque pixel on out_pixel_abgr with out_valid; the receiver drives
// out_stall. Every input beat gives exactly one result beat, in order.
// From the edge that accepts an input beat to out_valid, the beat passes 68
// registers, and the first is loaded at that edge: one input stage, 32 cells
// of the count/limit divider, 16 cells of the square root, one segment stage,
// 16 cells of the in-segment divider, one multiply stage and the output
// register. Palette and iteration limit are written through cfg_wen, cfg_index
// and cfg_wdata while no beat is in flight, a user rule the block does not
// enforce. The limit saturates to 1..4096. Reset selects the first palette
// with a limit of 256 and empties the chain. A new beat is taken every cycle
// unless a result beat waits under out_stall; the whole chain then holds still
// and in_stall rises, so no beat is lost; it moves again the cycle stall drops.
module escape_count_gradient_colour_map (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [12:0] in_escape_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_pixel_abgr,
  input  wire logic        cfg_wen,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_wdata
);
  import ecgcm_pkg::*;

  localparam int QSTEPS = 32;
  localparam int RSTEPS = 16;
  localparam int FSTEPS = 16;

  logic        adv;
  pal_t        pal_r;
  logic [12:0] limit_r, limit_nxt;

  // Configuration registers.
  always_comb begin
    if (cfg_wdata == 13'd0) begin
      limit_nxt = 13'd1;
    end else if (cfg_wdata > 13'(ITER_CAP)) begin
      limit_nxt = 13'(ITER_CAP);
    end else begin
      limit_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r   <= '0;
      limit_r <= 13'd256;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_PALETTE: pal_r   <= cfg_wdata[1:0];
        REG_LIMIT:   limit_r <= limit_nxt;
        default:     ;
      endcase
    end
  end

  logic out_valid_r;
  logic [31:0] out_pixel_r, out_pixel_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Count/limit divider chain: quotient is floor(count * 2^32 / limit).
  side_t       dv_side [QSTEPS+1];
  logic [16:0] dv_rem  [QSTEPS+1];
  logic [16:0] dv_div  [QSTEPS+1];
  logic [31:0] dv_quo  [QSTEPS+1];

  side_t       in_side_r;
  logic [12:0] in_count_r;
  logic [12:0] in_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_side_r <= '0;
    end else if (adv) begin
      in_side_r.valid <= in_valid;
      in_side_r.black <= in_escape_count >= limit_r;
      in_side_r.pal   <= pal_r;
      in_side_r.seg   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_count_r <= in_escape_count;
      in_limit_r <= limit_r;
    end
  end

  assign dv_side[0] = in_side_r;
  assign dv_rem[0]  = {4'd0, in_count_r};
  assign dv_div[0]  = {4'd0, in_limit_r};
  assign dv_quo[0]  = '0;

  for (genvar k = 0; k < QSTEPS; k++) begin : g_qdiv
    ecgcm_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .side_i (dv_side[k]),
      .rem_i  (dv_rem[k]),
      .div_i  (dv_div[k]),
      .quo_i  (dv_quo[k]),
      .side_o (dv_side[k+1]),
      .rem_o  (dv_rem[k+1]),
      .div_o  (dv_div[k+1]),
      .quo_o  (dv_quo[k+1])
    );
  end

  // Square root chain gives the gradient position t in Q0.16.
  side_t       sq_side [RSTEPS+1];
  logic [31:0] sq_v    [RSTEPS+1];
  logic [18:0] sq_rem  [RSTEPS+1];
  logic [15:0] sq_root [RSTEPS+1];

  assign sq_side[0] = dv_side[QSTEPS];
  assign sq_v[0]    = dv_quo[QSTEPS];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < RSTEPS; k++) begin : g_sqrt
    ecgcm_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .side_i (sq_side[k]),
      .v_i    (sq_v[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .side_o (sq_side[k+1]),
      .v_o    (sq_v[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1])
    );
  end

  // Segment stage: first stop at or beyond t, then the top quotient bit of f.
  side_t       sg_side_nxt, sg_side_r;
  seg_t        seg;
  logic [16:0] t17, ta, span, offs;
  logic        f_top;
  logic [16:0] sg_rem_r, sg_span_r;
  logic        sg_top_r;

  always_comb begin
    t17 = {1'b0, sq_root[RSTEPS]};
    seg = 3'(NSTOP - 1);
    for (int i = NSTOP - 1; i >= 1; i--) begin
      if (t17 <= STOP_POS[sq_side[RSTEPS].pal][i]) begin
        seg = 3'(i);
      end
    end
    ta    = STOP_POS[sq_side[RSTEPS].pal][seg - 3'd1];
    span  = STOP_POS[sq_side[RSTEPS].pal][seg] - ta;
    offs  = t17 - ta;
    f_top = offs >= span;
    sg_side_nxt     = sq_side[RSTEPS];
    sg_side_nxt.seg = seg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sg_side_r <= '0;
    end else if (adv) begin
      sg_side_r <= sg_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sg_rem_r  <= f_top ? 17'(offs - span) : offs;
      sg_span_r <= span;
      sg_top_r  <= f_top;
    end
  end

  // In-segment divider chain: f = floor((t - ta) * 65536 / span).
  side_t       fd_side [FSTEPS+1];
  logic [16:0] fd_rem  [FSTEPS+1];
  logic [16:0] fd_div  [FSTEPS+1];
  logic [31:0] fd_quo  [FSTEPS+1];

  assign fd_side[0] = sg_side_r;
  assign fd_rem[0]  = sg_rem_r;
  assign fd_div[0]  = sg_span_r;
  assign fd_quo[0]  = {31'd0, sg_top_r};

  for (genvar k = 0; k < FSTEPS; k++) begin : g_fdiv
    ecgcm_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .side_i (fd_side[k]),
      .rem_i  (fd_rem[k]),
      .div_i  (fd_div[k]),
      .quo_i  (fd_quo[k]),
      .side_o (fd_side[k+1]),
      .rem_o  (fd_rem[k+1]),
      .div_o  (fd_div[k+1]),
      .quo_o  (fd_quo[k+1])
    );
  end

  // Multiply stage: f * (b - a) per channel.
  side_t              fin_side;
  side_t              mu_side_r;
  logic signed [27:0] mu_prod_r [3];
  logic signed [27:0] mu_prod_nxt [3];
  logic signed [17:0] f_s;
  logic signed [9:0]  delta [3];

  assign fin_side = fd_side[FSTEPS];

  always_comb begin
    f_s = $signed({1'b0, fd_quo[FSTEPS][16:0]});
    for (int k = 0; k < 3; k++) begin
      delta[k] = $signed({2'b00, STOP_RGB[fin_side.pal][fin_side.seg][k]})
               - $signed({2'b00, STOP_RGB[fin_side.pal][fin_side.seg - 3'd1][k]});
      mu_prod_nxt[k] = f_s * delta[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_side_r <= '0;
    end else if (adv) begin
      mu_side_r <= fin_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mu_prod_r <= mu_prod_nxt;
    end
  end

  // Output stage: add the start colour with rounding, clamp, pack.
  logic signed [27:0] acc [3];
  logic [7:0]         chan [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = $signed({4'd0, STOP_RGB[mu_side_r.pal][mu_side_r.seg - 3'd1][k], 16'd0})
             + mu_prod_r[k] + 28'sd32768;
      if (acc[k] < 0) begin
        chan[k] = 8'd0;
      end else if (acc[k][27:16] > 12'd255) begin
        chan[k] = 8'd255;
      end else begin
        chan[k] = acc[k][23:16];
      end
    end
    out_pixel_nxt = mu_side_r.black ? BLACK_PIXEL : {8'hFF, chan[2], chan[1], chan[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= mu_side_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel_r <= out_pixel_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_abgr = out_pixel_r;

  a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel_abgr[31:24] == 8'hFF)
    else $error("result beat without opaque alpha");

  a_qdiv_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_side[QSTEPS].valid && !dv_side[QSTEPS].black) |->
      dv_rem[QSTEPS] < dv_div[QSTEPS])
    else $error("count divider remainder not below limit");

  a_fdiv_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_side.valid && fd_div[FSTEPS] != 17'd0) |-> fd_rem[FSTEPS] < fd_div[FSTEPS])
    else $error("segment divider remainder not below span");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(mu_side_r))
    else $error("chain moved while result beat stalled");

endmodule
`default_nettype wire
